/* sv/mpc_pkg.sv */
package mpc_pkg;

    // field widths
    localparam int LON_W    = 16;
    localparam int LAT_W    = 15;
    localparam int COORD_W  = 18;   // mapped screen coordinate, signed
    localparam int ZPOS_W   = 27;   // zoomed screen coordinate, signed
    localparam int PIX_W    = 13;   // output pixel coordinate
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // projection constants
    localparam int LON_OFFSET = 18000;
    localparam int LON_SPAN   = 36000;
    localparam int LAT_OFFSET = 9000;
    localparam int LAT_SPAN   = 18000;
    localparam int PERCENT    = 100;

    // reciprocal scaling for constant division
    localparam int     REC_SHIFT = 30;
    localparam longint REC_ONE   = longint'(1) << REC_SHIFT;

    // pipeline depth of the datapath units
    localparam int MAP_LAT  = 4;
    localparam int ZOOM_LAT = 5;
    localparam int PIPE_LAT = MAP_LAT + ZOOM_LAT;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AREA_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_PERCENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_SET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_LON   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_LAT   = 3'd7;

    // one queued vertex
    typedef struct packed {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
        logic                    first_point;
    } t_vtx;

    // configuration seen by the datapath
    typedef struct packed {
        logic [11:0]             area_left;
        logic [11:0]             area_top;
        logic [12:0]             area_width;
        logic [12:0]             area_height;
        logic [10:0]             zoom_percent;
        logic                    center_set;
        logic signed [LON_W-1:0] center_lon;
        logic signed [LAT_W-1:0] center_lat;
    } t_cfg;

endpackage

/* sv/mpc_front.sv */
module mpc_front #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mpc_pkg::t_vtx i_item,
    output logic          o_head_vld,
    output mpc_pkg::t_vtx o_head,
    input  logic          i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    mpc_pkg::t_vtx    r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             push;
    logic             pop;

    // queue status
    assign o_ready    = (r_count != CntW'(DEPTH));
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign push       = i_valid && o_ready;
    assign pop        = i_pop && o_head_vld;

    // item storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/mpc_map.sv */
module mpc_map #(
    parameter bit AXIS_Y = 1'b0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [mpc_pkg::LON_W-1:0]   i_coord,
    input  logic [11:0]                        i_org,
    input  logic [12:0]                        i_size,
    output logic signed [mpc_pkg::COORD_W-1:0] o_pos
);

    localparam int     Div  = AXIS_Y ? mpc_pkg::LAT_SPAN : mpc_pkg::LON_SPAN;
    localparam longint Rec  = mpc_pkg::REC_ONE / Div;
    localparam logic [15:0] RecV = 16'(Rec);

    logic signed [16:0] n_t;
    logic signed [30:0] n_prod;
    logic [29:0]        n_mag;
    logic [45:0]        n_full;
    logic [31:0]        qd;
    logic [29:0]        rem;
    logic [16:0]        n_qc;
    logic signed [17:0] q_s;
    logic signed [17:0] n_pos;

    logic signed [30:0] r_prod;
    logic [29:0]        r_mag;
    logic [15:0]        r_q;
    logic               r_neg_b;
    logic [16:0]        r_qc;
    logic               r_neg_c;
    logic signed [17:0] r_pos;

    // offset the angle and scale by the area size
    always_comb begin
        if (AXIS_Y) begin
            n_t = 17'(mpc_pkg::LAT_OFFSET) - 17'(i_coord);
        end else begin
            n_t = 17'(i_coord) + 17'(mpc_pkg::LON_OFFSET);
        end
        n_prod = 31'(n_t) * $signed({18'd0, i_size});
    end

    // magnitude times reciprocal, estimate low by at most one
    always_comb begin
        n_mag  = r_prod[30] ? 30'(-r_prod) : 30'(r_prod);
        n_full = 46'(n_mag) * 46'(RecV);
    end

    // correct the estimate
    always_comb begin
        qd   = 32'(r_q) * 32'(Div);
        rem  = r_mag - qd[29:0];
        n_qc = (rem >= 30'(Div)) ? 17'(r_q) + 17'd1 : 17'(r_q);
    end

    // restore sign (truncation toward zero) and add the area origin
    always_comb begin
        q_s   = $signed({1'b0, r_qc});
        n_pos = (r_neg_c ? -q_s : q_s) + $signed({6'd0, i_org});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_mag   <= n_mag;
            r_q     <= n_full[mpc_pkg::REC_SHIFT +: 16];
            r_neg_b <= r_prod[30];
            r_qc    <= n_qc;
            r_neg_c <= r_neg_b;
            r_pos   <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

/* sv/mpc_zoom.sv */
module mpc_zoom (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [mpc_pkg::COORD_W-1:0] i_b,
    input  logic signed [mpc_pkg::COORD_W-1:0] i_c,
    input  logic [10:0]                        i_zoom,
    output logic signed [mpc_pkg::ZPOS_W-1:0]  o_p
);

    localparam longint Rec  = mpc_pkg::REC_ONE / mpc_pkg::PERCENT;
    localparam logic [23:0] RecP = 24'(Rec);

    logic signed [30:0] n_prod;
    logic [29:0]        n_mag;
    logic [53:0]        n_full;
    logic [30:0]        qd;
    logic [29:0]        rem;
    logic [24:0]        n_qc;
    logic signed [26:0] q_s;
    logic signed [26:0] n_p;

    logic signed [18:0] r_diff;
    logic signed [17:0] r_c_a;
    logic signed [30:0] r_prod;
    logic signed [17:0] r_c_b;
    logic [29:0]        r_mag;
    logic [23:0]        r_q;
    logic               r_neg_c;
    logic signed [17:0] r_c_c;
    logic [24:0]        r_qc;
    logic               r_neg_d;
    logic signed [17:0] r_c_d;
    logic signed [26:0] r_p;

    // offset from centre times zoom
    assign n_prod = 31'(r_diff) * $signed({20'd0, i_zoom});

    // divide by one hundred through the reciprocal
    always_comb begin
        n_mag  = r_prod[30] ? 30'(-r_prod) : 30'(r_prod);
        n_full = 54'(n_mag) * 54'(RecP);
    end

    always_comb begin
        qd   = 31'(r_q) * 31'(mpc_pkg::PERCENT);
        rem  = r_mag - qd[29:0];
        n_qc = (rem >= 30'(mpc_pkg::PERCENT)) ? 25'(r_q) + 25'd1 : 25'(r_q);
    end

    // signed quotient back onto the centre
    always_comb begin
        q_s = $signed({2'b0, r_qc});
        n_p = (r_neg_d ? -q_s : q_s) + 27'(r_c_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff  <= 19'(i_b) - 19'(i_c);
            r_c_a   <= i_c;
            r_prod  <= n_prod;
            r_c_b   <= r_c_a;
            r_mag   <= n_mag;
            r_q     <= n_full[mpc_pkg::REC_SHIFT +: 24];
            r_neg_c <= r_prod[30];
            r_c_c   <= r_c_b;
            r_qc    <= n_qc;
            r_neg_d <= r_neg_c;
            r_c_d   <= r_c_c;
            r_p     <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* sv/mpc_back.sv */
module mpc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mpc_pkg::t_cfg                  i_cfg,
    input  logic                           i_head_vld,
    input  mpc_pkg::t_vtx                  i_head,
    output logic                           o_pop,
    output logic                           o_out_vld,
    input  logic                           i_out_ready,
    output logic                           o_draw,
    output logic [mpc_pkg::PIX_W-1:0]      o_px,
    output logic [mpc_pkg::PIX_W-1:0]      o_py
);

    localparam int L = mpc_pkg::PIPE_LAT;

    logic                               en;
    logic signed [mpc_pkg::COORD_W-1:0] bx;
    logic signed [mpc_pkg::COORD_W-1:0] by;
    logic signed [mpc_pkg::COORD_W-1:0] cx_map;
    logic signed [mpc_pkg::COORD_W-1:0] cy_map;
    logic signed [mpc_pkg::COORD_W-1:0] cx;
    logic signed [mpc_pkg::COORD_W-1:0] cy;
    logic signed [mpc_pkg::ZPOS_W-1:0]  px;
    logic signed [mpc_pkg::ZPOS_W-1:0]  py;
    logic [13:0]                        x_end;
    logic [13:0]                        y_end;
    logic                               in_area;
    logic                               pen_cur;

    logic [L-1:0]                       r_vld;
    logic [L-1:0]                       r_first;
    logic                               r_pen;
    logic                               r_out_vld;
    logic                               r_draw;
    logic [mpc_pkg::PIX_W-1:0]          r_px;
    logic [mpc_pkg::PIX_W-1:0]          r_py;

    // the whole datapath advances when the output register can take an item
    assign en    = !r_out_vld || i_out_ready;
    assign o_pop = en;

    // vertex and configured centre mapped onto the area
    mpc_map #(.AXIS_Y(1'b0)) u_map_bx (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_head.lon),
        .i_org   (i_cfg.area_left),
        .i_size  (i_cfg.area_width),
        .o_pos   (bx)
    );

    mpc_map #(.AXIS_Y(1'b1)) u_map_by (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (16'(i_head.lat)),
        .i_org   (i_cfg.area_top),
        .i_size  (i_cfg.area_height),
        .o_pos   (by)
    );

    mpc_map #(.AXIS_Y(1'b0)) u_map_cx (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_cfg.center_lon),
        .i_org   (i_cfg.area_left),
        .i_size  (i_cfg.area_width),
        .o_pos   (cx_map)
    );

    mpc_map #(.AXIS_Y(1'b1)) u_map_cy (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (16'(i_cfg.center_lat)),
        .i_org   (i_cfg.area_top),
        .i_size  (i_cfg.area_height),
        .o_pos   (cy_map)
    );

    // zoom centre: configured point or area middle
    assign cx = i_cfg.center_set ? cx_map
              : $signed({6'd0, i_cfg.area_left}) + $signed({6'd0, i_cfg.area_width[12:1]});
    assign cy = i_cfg.center_set ? cy_map
              : $signed({6'd0, i_cfg.area_top}) + $signed({6'd0, i_cfg.area_height[12:1]});

    mpc_zoom u_zoom_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_b    (bx),
        .i_c    (cx),
        .i_zoom (i_cfg.zoom_percent),
        .o_p    (px)
    );

    mpc_zoom u_zoom_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_b    (by),
        .i_c    (cy),
        .i_zoom (i_cfg.zoom_percent),
        .o_p    (py)
    );

    // clip against the area
    always_comb begin
        x_end   = 14'(i_cfg.area_left) + 14'(i_cfg.area_width);
        y_end   = 14'(i_cfg.area_top) + 14'(i_cfg.area_height);
        in_area = (px >= $signed({15'd0, i_cfg.area_left}))
               && (px <  $signed({13'd0, x_end}))
               && (py >= $signed({15'd0, i_cfg.area_top}))
               && (py <  $signed({13'd0, y_end}));
        pen_cur = r_first[L-1] ? 1'b0 : r_pen;
    end

    // item flags travelling alongside the datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_first <= {r_first[L-2:0], i_head.first_point};
        end
    end

    // valid chain, pen state and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_pen     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[L-2:0], i_head_vld};
            r_out_vld <= r_vld[L-1] && in_area;
            if (r_vld[L-1]) begin
                r_pen <= in_area;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (en && r_vld[L-1] && in_area) begin
            r_draw <= pen_cur;
            r_px   <= px[mpc_pkg::PIX_W-1:0];
            r_py   <= py[mpc_pkg::PIX_W-1:0];
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_draw    = r_draw;
    assign o_px      = r_px;
    assign o_py      = r_py;

endmodule

/* sv/map_point_project_clip.sv */
// channel   dir  handshake                       payload
// --------  ---  ------------------------------  ------------------------------------
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata lon, lat; tuser first_point
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata px, py; tuser draw_line
// cfg       in   i_cfg_we (no wait)              i_cfg_idx register, i_cfg_data value
//
// one item per cycle is taken while no result stalls on m_axis; the datapath is a nine-stage
// pipeline, four stages of mapping then five of zoom, with constant divisions by reciprocal
// an accepted item passes the input queue, the mapping and zoom stages and the output register
// a result held on m_axis with m_axis_tready low freezes the whole pipeline;
// the input queue of QUEUE_DEPTH items keeps s_axis_tready high until it fills
// synchronous reset empties the queue and pipeline, lifts the pen and
// returns the registers to their defaults
module map_point_project_clip #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,   // lon[15:0], lat[30:16], zero
    input  logic [0:0]                         s_axis_tuser,   // first_point
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,   // px[12:0], py[25:13], zero
    output logic [0:0]                         m_axis_tuser,   // draw_line
    input  logic                               i_cfg_we,
    input  logic [mpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    mpc_pkg::t_cfg              r_cfg;
    mpc_pkg::t_vtx              in_item;
    mpc_pkg::t_vtx              head;
    logic                       head_vld;
    logic                       pop;
    logic                       draw;
    logic [mpc_pkg::PIX_W-1:0]  px;
    logic [mpc_pkg::PIX_W-1:0]  py;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_left    <= 12'd0;
            r_cfg.area_top     <= 12'd0;
            r_cfg.area_width   <= 13'd640;
            r_cfg.area_height  <= 13'd360;
            r_cfg.zoom_percent <= 11'd100;
            r_cfg.center_set   <= 1'b0;
            r_cfg.center_lon   <= '0;
            r_cfg.center_lat   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mpc_pkg::REG_AREA_LEFT:    r_cfg.area_left    <= i_cfg_data[11:0];
                mpc_pkg::REG_AREA_TOP:     r_cfg.area_top     <= i_cfg_data[11:0];
                mpc_pkg::REG_AREA_WIDTH:   r_cfg.area_width   <= i_cfg_data[12:0];
                mpc_pkg::REG_AREA_HEIGHT:  r_cfg.area_height  <= i_cfg_data[12:0];
                mpc_pkg::REG_ZOOM_PERCENT: r_cfg.zoom_percent <= i_cfg_data[10:0];
                mpc_pkg::REG_CENTER_SET:   r_cfg.center_set   <= i_cfg_data[0];
                mpc_pkg::REG_CENTER_LON:   r_cfg.center_lon   <= $signed(i_cfg_data[15:0]);
                mpc_pkg::REG_CENTER_LAT:   r_cfg.center_lat   <= $signed(i_cfg_data[14:0]);
                default: ;
            endcase
        end
    end

    // unpack the input item
    always_comb begin
        in_item.lon         = $signed(s_axis_tdata[15:0]);
        in_item.lat         = $signed(s_axis_tdata[30:16]);
        in_item.first_point = s_axis_tuser[0];
    end

    mpc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .o_head_vld (head_vld),
        .o_head     (head),
        .i_pop      (pop)
    );

    mpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head_vld  (head_vld),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_vld   (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_draw      (draw),
        .o_px        (px),
        .o_py        (py)
    );

    // pack the result item
    assign m_axis_tdata = {6'd0, py, px};
    assign m_axis_tuser = draw;

endmodule

/* sv/mpc_checker.sv */
module mpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic        in_acc;
    logic        out_acc;
    logic [31:0] r_pend;
    logic        r_seen_out;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items taken less results delivered (clipped items stay counted), and whether any result has gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= '0;
            r_seen_out <= 1'b0;
        end else begin
            if (in_acc && !out_acc) begin
                r_pend <= r_pend + 1'b1;
            end else if (out_acc && !in_acc) begin
                r_pend <= r_pend - 1'b1;
            end
            if (out_acc) begin
                r_seen_out <= 1'b1;
            end
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // no result without an item behind it
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != '0)
        else $error("result without a pending item");

    // the pen starts up, so the first result is a move
    a_first_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_seen_out |-> m_axis_tuser[0] == 1'b0)
        else $error("first result is a draw");

endmodule

bind map_point_project_clip mpc_checker u_mpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
